// ----- sv/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// tpp_pkg: shared types and constants for the timer period/prescale calculator
// Holds field widths, divider sizing, FSM state encoding and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int CLOCK_W     = 27;
  localparam int FREQ_W      = 24;
  localparam int PERIOD_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int CODE_W      = 3;

  // numerator is 2 * clock_hz * 2^FRAC_BITS
  localparam int NUM_W = CLOCK_W + 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int EXP_W = 4;

  localparam logic [CLOCK_W-1:0]     CLOCK_RESET = CLOCK_W'(30000000);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX  = {PERIOD_BITS{1'b1}};
  localparam logic [PERIOD_BITS-1:0] PERIOD_HALF = PERIOD_MAX >> 1;
  localparam logic [EXP_W-1:0]       EXP_MAX     = EXP_W'(8);
  localparam logic [EXP_W-1:0]       EXP_NONE    = EXP_W'(7);
  localparam logic [EXP_W-1:0]       EXP_LOWER   = EXP_W'(6);
  localparam logic [CODE_W-1:0]      CODE_DIV256 = 3'b111;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_STRIP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scale_step;
    logic strip_step;
    logic oor_set;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_last;
    logic over;
    logic exp_at_max;
    logic strip_go;
  } dp_stat_t;

endpackage

// ----- sv/timer_period_prescale_calc.sv -----
// ----------------------------------------------------------------------------
// timer_period_prescale_calc: timer prescale code and period from a frequency
// A zero frequency skips straight to hold; otherwise the 36-step bit-serial
//   divider runs, then scale and strip shifts (they share the exponent, at most
//   8 in all). One transaction at a time: a new frequency is taken only once
//   the previous result has been loaded into the output register.
// Reset: synchronous, active high; clock_hz returns to 30 MHz, no result held.
// ----------------------------------------------------------------------------
module timer_period_prescale_calc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tpp_pkg::CLOCK_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tpp_pkg::FREQ_W-1:0]      freq_q8,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tpp_pkg::CODE_W-1:0]      prescale_code,
  output logic [tpp_pkg::PERIOD_BITS-1:0] period,
  output logic                            out_of_range
);
  import tpp_pkg::*;

  // Flow of one transaction:
  //   accept   - capture the frequency and load 2*clock_hz*256 as numerator
  //   divide   - one quotient bit per cycle, remainder kept for the fraction
  //   scale    - halve while the exact quotient exceeds the period maximum,
  //              counting the prescale exponent; passing 8 saturates
  //   strip    - drop trailing zeros of the period while exponent is below 8
  //   hold     - wait for the result register to free up, then load it
  // The output register decouples the sink: a result waiting under stall
  // does not block the sequencer until the next result is ready to load.

  ctl_cmd_t cmd;
  dp_stat_t stat;

  tpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .freq_q8       (freq_q8),
    .cmd           (cmd),
    .stat          (stat),
    .prescale_code (prescale_code),
    .period        (period),
    .out_of_range  (out_of_range)
  );

endmodule

// ----- sv/tpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpp_ctrl: sequencer for the timer period/prescale calculator
// Steps the datapath through division, range scaling and zero stripping,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module tpp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tpp_pkg::dp_stat_t stat,
  output tpp_pkg::ctl_cmd_t cmd
);
  import tpp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.den_zero ? ST_HOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!stat.over) begin
          state_next = ST_STRIP;
        end else if (stat.exp_at_max) begin
          // one more halving would pass divide-by-256: saturate
          cmd.oor_set = 1'b1;
          state_next  = ST_HOLD;
        end else begin
          cmd.scale_step = 1'b1;
        end
      end
      ST_STRIP: begin
        if (stat.strip_go) begin
          cmd.strip_step = 1'b1;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/tpp_datapath.sv -----
// ----------------------------------------------------------------------------
// tpp_datapath: arithmetic for the timer period/prescale calculator
// Bit-serial restoring divider, exponent scaling shifter, trailing-zero
// stripper, clock register and result register.
// ----------------------------------------------------------------------------
module tpp_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tpp_pkg::CLOCK_W-1:0]        cfg_wdata,
  input  logic [tpp_pkg::FREQ_W-1:0]         freq_q8,
  input  tpp_pkg::ctl_cmd_t                  cmd,
  output tpp_pkg::dp_stat_t                  stat,
  output logic [tpp_pkg::CODE_W-1:0]         prescale_code,
  output logic [tpp_pkg::PERIOD_BITS-1:0]    period,
  output logic                               out_of_range
);
  import tpp_pkg::*;

  logic [CLOCK_W-1:0]     clock_hz;
  logic [FREQ_W-1:0]      den;
  logic [FREQ_W-1:0]      rem;
  logic [NUM_W-1:0]       w;
  logic [CNT_W-1:0]       cnt;
  logic [EXP_W-1:0]       expo;
  logic                   sticky;
  logic                   oor;

  logic [FREQ_W:0]        trial;
  logic [FREQ_W:0]        diff;
  logic                   qbit;
  logic                   frac;
  logic [CODE_W-1:0]      code_res;
  logic [PERIOD_BITS-1:0] period_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
    end else if (cfg_we) begin
      clock_hz <= cfg_wdata;
    end
  end

  // restoring divider step: shift in next numerator bit, subtract if it fits
  assign trial = {rem, w[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign qbit  = !diff[FREQ_W];

  // fraction below the current whole part: shifted-out bits or remainder
  assign frac = sticky || (rem != '0);

  assign stat.den_zero   = (freq_q8 == '0);
  assign stat.div_last   = (cnt == CNT_W'(NUM_W - 1));
  assign stat.over       = (w[NUM_W-1:PERIOD_BITS] != '0) ||
                           ((w[PERIOD_BITS-1:0] == PERIOD_MAX) && frac);
  assign stat.exp_at_max = (expo == EXP_MAX);
  assign stat.strip_go   = !w[0] && (expo < EXP_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den    <= freq_q8;
      rem    <= '0;
      w      <= {clock_hz, 1'b0, {FRAC_BITS{1'b0}}};
      cnt    <= '0;
      expo   <= '0;
      sticky <= 1'b0;
    end else if (cmd.div_step) begin
      rem <= qbit ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      w   <= {w[NUM_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end else if (cmd.scale_step || cmd.strip_step) begin
      w      <= w >> 1;
      expo   <= expo + 1'b1;
      sticky <= sticky | w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      oor <= (freq_q8 == '0);
    end else if (cmd.oor_set) begin
      oor <= 1'b1;
    end
  end

  // there is no divide-by-128: move to 64 or 256 depending on headroom
  always_comb begin
    if (oor) begin
      code_res   = CODE_DIV256;
      period_res = PERIOD_MAX;
    end else if (expo == EXP_NONE) begin
      if (w[PERIOD_BITS-1:0] > PERIOD_HALF) begin
        code_res   = CODE_DIV256;
        period_res = w[PERIOD_BITS-1:0] >> 1;
      end else begin
        code_res   = CODE_W'(EXP_LOWER);
        period_res = {w[PERIOD_BITS-2:0], 1'b0};
      end
    end else if (expo == EXP_MAX) begin
      code_res   = CODE_DIV256;
      period_res = w[PERIOD_BITS-1:0];
    end else begin
      code_res   = expo[CODE_W-1:0];
      period_res = w[PERIOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      prescale_code <= code_res;
      period        <= period_res;
      out_of_range  <= oor;
    end
  end

endmodule
